// ===== rtl/ule_pkg.sv =====
// ule_pkg: shared types and constants for the UART line echo block.
// Holds the phase encoding, the receive transaction record and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package ule_pkg;

  localparam int TICK_W    = 12;
  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [TICK_W-1:0] BIT_TICKS_RST = 12'd205;
  localparam logic [BYTE_W-1:0] LINE_END_RST  = 8'h0D;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIT_TICKS = 1'b0,
    REG_LINE_END  = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_START = 4'b0010,
    PH_DATA  = 4'b0100,
    PH_STOP  = 4'b1000
  } phase_t;

  // One tick as seen by the back end: byte completion and its value.
  typedef struct packed {
    logic              done;
    logic [BYTE_W-1:0] value;
  } rx_evt_t;

endpackage

// ===== rtl/ule_rx_front.sv =====
// ule_rx_front: 8N1 receiver, one transaction per tick, emits a receive record per tick.
// Depends on ule_pkg.
`timescale 1ns / 1ps

module ule_rx_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ule_pkg::TICK_W-1:0]  bit_ticks,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_rx_level,
  input  logic                        q_full,
  output logic                        q_push,
  output ule_pkg::rx_evt_t            q_evt
);
  import ule_pkg::*;

  phase_t              rx_phase_r, rx_phase_nxt;
  logic [TICK_W-1:0]   rx_cnt_r, rx_cnt_nxt;
  logic [2:0]          rx_bitc_r, rx_bitc_nxt;
  logic [BYTE_W-1:0]   rx_shift_r, rx_shift_nxt;
  logic [TICK_W-1:0]   cnt_inc;
  logic [TICK_W-1:0]   half_ticks;
  logic                full_hit;
  logic                half_hit;

  assign in_ready   = !q_full;
  assign q_push     = in_valid && in_ready;
  assign cnt_inc    = rx_cnt_r + 12'd1;
  assign half_ticks = bit_ticks >> 1;
  assign full_hit   = cnt_inc >= bit_ticks;
  assign half_hit   = cnt_inc >= half_ticks;

  always_comb begin
    rx_phase_nxt = rx_phase_r;
    rx_cnt_nxt   = rx_cnt_r;
    rx_bitc_nxt  = rx_bitc_r;
    rx_shift_nxt = rx_shift_r;
    q_evt.done   = 1'b0;
    q_evt.value  = '0;
    unique case (rx_phase_r)
      PH_IDLE: begin
        if (!in_rx_level) begin
          rx_phase_nxt = PH_START;
          rx_cnt_nxt   = '0;
        end
      end
      PH_START: begin
        if (half_hit) begin
          rx_cnt_nxt = '0;
          if (in_rx_level) begin
            rx_phase_nxt = PH_IDLE;
          end else begin
            rx_phase_nxt = PH_DATA;
            rx_bitc_nxt  = '0;
            rx_shift_nxt = '0;
          end
        end else begin
          rx_cnt_nxt = cnt_inc;
        end
      end
      PH_DATA: begin
        if (full_hit) begin
          rx_cnt_nxt   = '0;
          rx_shift_nxt = {in_rx_level, rx_shift_r[BYTE_W-1:1]};
          if (rx_bitc_r == 3'd7) begin
            rx_phase_nxt = PH_STOP;
          end else begin
            rx_bitc_nxt = rx_bitc_r + 3'd1;
          end
        end else begin
          rx_cnt_nxt = cnt_inc;
        end
      end
      PH_STOP: begin
        if (full_hit) begin
          rx_cnt_nxt   = '0;
          rx_phase_nxt = PH_IDLE;
          rx_bitc_nxt  = '0;
          q_evt.done   = 1'b1;
          q_evt.value  = rx_shift_r;
        end else begin
          rx_cnt_nxt = cnt_inc;
        end
      end
      default: begin
        rx_phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_phase_r <= PH_IDLE;
      rx_cnt_r   <= '0;
      rx_bitc_r  <= '0;
      rx_shift_r <= '0;
    end else if (q_push) begin
      rx_phase_r <= rx_phase_nxt;
      rx_cnt_r   <= rx_cnt_nxt;
      rx_bitc_r  <= rx_bitc_nxt;
      rx_shift_r <= rx_shift_nxt;
    end
  end

endmodule

// ===== rtl/ule_evt_fifo.sv =====
// ule_evt_fifo: two-entry queue of receive records between front and back end.
// Depends on ule_pkg.
`timescale 1ns / 1ps

module ule_evt_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ule_pkg::rx_evt_t  push_evt,
  output logic              full,
  input  logic              pop,
  output logic              avail,
  output ule_pkg::rx_evt_t  head_evt
);
  import ule_pkg::*;

  rx_evt_t     slot_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r, count_nxt;

  assign full     = count_r == 2'd2;
  assign avail    = count_r != 2'd0;
  assign head_evt = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_evt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/ule_echo_back.sv =====
// ule_echo_back: line store, echo transmitter and output register.
// Consumes one receive record per transaction; depends on ule_pkg.
`timescale 1ns / 1ps

module ule_echo_back #(
  parameter int LINE_DEPTH = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ule_pkg::TICK_W-1:0]  bit_ticks,
  input  logic [ule_pkg::BYTE_W-1:0]  line_end_char,
  input  logic                        q_avail,
  input  ule_pkg::rx_evt_t            q_evt,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_tx_level,
  output logic                        out_byte_done,
  output logic [ule_pkg::BYTE_W-1:0]  out_byte_value,
  output logic                        out_echo_busy,
  output logic                        out_byte_dropped
);
  import ule_pkg::*;

  localparam int FW = $clog2(LINE_DEPTH + 1);
  localparam int AW = $clog2(LINE_DEPTH);
  localparam logic [FW-1:0] DEPTH_F      = FW'(LINE_DEPTH);
  localparam logic [FW-1:0] DEPTH_LESS_1 = FW'(LINE_DEPTH - 1);

  logic [BYTE_W-1:0]  store_mem [LINE_DEPTH];
  logic [BYTE_W-1:0]  rd_data_r;

  phase_t             tx_phase_r, tx_phase_nxt;
  logic [TICK_W-1:0]  tx_cnt_r, tx_cnt_nxt;
  logic [3:0]         tx_bitc_r, tx_bitc_nxt;
  logic [BYTE_W-1:0]  tx_shift_r, tx_shift_nxt;
  logic [FW-1:0]      send_idx_r, send_idx_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic               ld_pend_r, ld_pend_nxt;

  logic               out_valid_r;
  logic               out_tx_r, out_done_r, out_busy_r, out_drop_r;
  logic [BYTE_W-1:0]  out_value_r;

  logic [BYTE_W-1:0]  shift_eff;
  logic               busy;
  logic               txl;
  logic               dropped;
  logic               start_echo;
  logic               wr_en;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [FW-1:0]      fill_acc;
  logic [FW-1:0]      idx_inc;
  logic [TICK_W-1:0]  cnt_inc;
  logic [3:0]         bitc_inc;

  assign q_pop     = q_avail && (!out_valid_r || out_ready);
  assign shift_eff = ld_pend_r ? rd_data_r : tx_shift_r;
  assign busy      = tx_phase_r != PH_IDLE;
  assign cnt_inc   = tx_cnt_r + 12'd1;
  assign bitc_inc  = tx_bitc_r + 4'd1;
  assign idx_inc   = send_idx_r + FW'(1);

  always_comb begin
    priority if (tx_phase_r == PH_START) txl = 1'b0;
    else if (tx_phase_r == PH_DATA) txl = shift_eff[0];
    else txl = 1'b1;
  end

  // Store decision for a completed byte.
  always_comb begin
    wr_en      = 1'b0;
    dropped    = 1'b0;
    start_echo = 1'b0;
    fill_acc   = fill_r;
    if (q_evt.done) begin
      priority if (busy) begin
        dropped = 1'b1;
      end else if (q_evt.value == line_end_char) begin
        if (fill_r < DEPTH_F) begin
          wr_en    = 1'b1;
          fill_acc = fill_r + FW'(1);
        end
        start_echo = 1'b1;
      end else if (fill_r < DEPTH_LESS_1) begin
        wr_en    = 1'b1;
        fill_acc = fill_r + FW'(1);
      end else begin
        dropped = 1'b1;
      end
    end
  end

  // Transmitter advance, then echo start.
  always_comb begin
    tx_phase_nxt = tx_phase_r;
    tx_cnt_nxt   = tx_cnt_r;
    tx_bitc_nxt  = tx_bitc_r;
    tx_shift_nxt = shift_eff;
    send_idx_nxt = send_idx_r;
    fill_nxt     = fill_acc;
    ld_pend_nxt  = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    if (busy) begin
      if (cnt_inc >= bit_ticks) begin
        tx_cnt_nxt = '0;
        unique case (tx_phase_r)
          PH_START: begin
            tx_phase_nxt = PH_DATA;
            tx_bitc_nxt  = '0;
          end
          PH_DATA: begin
            tx_shift_nxt = shift_eff >> 1;
            tx_bitc_nxt  = bitc_inc;
            if (bitc_inc >= 4'd8) tx_phase_nxt = PH_STOP;
          end
          PH_STOP: begin
            send_idx_nxt = idx_inc;
            if (idx_inc < fill_acc) begin
              rd_en        = 1'b1;
              rd_addr      = idx_inc[AW-1:0];
              ld_pend_nxt  = 1'b1;
              tx_phase_nxt = PH_START;
              tx_bitc_nxt  = '0;
            end else begin
              tx_phase_nxt = PH_IDLE;
              tx_bitc_nxt  = '0;
              tx_shift_nxt = '0;
              send_idx_nxt = '0;
              fill_nxt     = '0;
            end
          end
          default: begin
            tx_phase_nxt = PH_IDLE;
          end
        endcase
      end else begin
        tx_cnt_nxt = cnt_inc;
      end
    end
    if (start_echo && fill_acc != '0) begin
      send_idx_nxt = '0;
      rd_en        = 1'b1;
      rd_addr      = '0;
      ld_pend_nxt  = 1'b1;
      tx_phase_nxt = PH_START;
      tx_cnt_nxt   = '0;
      tx_bitc_nxt  = '0;
    end
  end

  // Line store: write-first on a same-address collision.
  always_ff @(posedge clk) begin
    if (q_pop && wr_en) store_mem[fill_r[AW-1:0]] <= q_evt.value;
    if (q_pop && rd_en) begin
      if (wr_en && fill_r[AW-1:0] == rd_addr) rd_data_r <= q_evt.value;
      else rd_data_r <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_phase_r  <= PH_IDLE;
      tx_cnt_r    <= '0;
      tx_bitc_r   <= '0;
      tx_shift_r  <= '0;
      send_idx_r  <= '0;
      fill_r      <= '0;
      ld_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        tx_phase_r  <= tx_phase_nxt;
        tx_cnt_r    <= tx_cnt_nxt;
        tx_bitc_r   <= tx_bitc_nxt;
        tx_shift_r  <= tx_shift_nxt;
        send_idx_r  <= send_idx_nxt;
        fill_r      <= fill_nxt;
        ld_pend_r   <= ld_pend_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_tx_r    <= txl;
      out_done_r  <= q_evt.done;
      out_value_r <= q_evt.value;
      out_busy_r  <= busy;
      out_drop_r  <= dropped;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tx_level     = out_tx_r;
  assign out_byte_done    = out_done_r;
  assign out_byte_value   = out_value_r;
  assign out_echo_busy    = out_busy_r;
  assign out_byte_dropped = out_drop_r;

endmodule

// ===== rtl/uart_line_echo.sv =====
// uart_line_echo: top level of the 8N1 line receiver with line echo.
// Instantiates ule_rx_front, ule_evt_fifo and ule_echo_back; depends on ule_pkg.
//
//   port group | direction | handshake           | payload
//   in_        | input     | in_valid/in_ready   | in_rx_level
//   out_       | output    | out_valid/out_ready | tx_level, byte_done, byte_value,
//              |           |                     | echo_busy, byte_dropped
//   cfg_       | input     | cfg_we              | cfg_addr, cfg_wdata
//
// One tick per clock while out_ready stays high; each tick gives exactly one result.
// An accepted tick's result passes a queue slot register, then the output register.
// During an output stall the queue takes one more tick, then in_ready drops.
// Reset is synchronous active low and needs no clearing pass; the line store is
// read only at entries written for the current line.
`timescale 1ns / 1ps

module uart_line_echo #(
  parameter int LINE_DEPTH = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_rx_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_tx_level,
  output logic                           out_byte_done,
  output logic [ule_pkg::BYTE_W-1:0]     out_byte_value,
  output logic                           out_echo_busy,
  output logic                           out_byte_dropped,
  input  logic                           cfg_we,
  input  logic [ule_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [ule_pkg::CFG_W-1:0]      cfg_wdata
);
  import ule_pkg::*;

  logic [TICK_W-1:0]  bit_ticks_r;
  logic [BYTE_W-1:0]  line_end_r;
  logic               q_full;
  logic               q_push;
  logic               q_pop;
  logic               q_avail;
  rx_evt_t            push_evt;
  rx_evt_t            head_evt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_ticks_r <= BIT_TICKS_RST;
      line_end_r  <= LINE_END_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_BIT_TICKS: bit_ticks_r <= cfg_wdata[TICK_W-1:0];
        REG_LINE_END:  line_end_r  <= cfg_wdata[BYTE_W-1:0];
        default:       ;
      endcase
    end
  end

  ule_rx_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .bit_ticks   (bit_ticks_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_rx_level (in_rx_level),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_evt       (push_evt)
  );

  ule_evt_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_evt (push_evt),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head_evt (head_evt)
  );

  ule_echo_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .bit_ticks        (bit_ticks_r),
    .line_end_char    (line_end_r),
    .q_avail          (q_avail),
    .q_evt            (head_evt),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tx_level     (out_tx_level),
    .out_byte_done    (out_byte_done),
    .out_byte_value   (out_byte_value),
    .out_echo_busy    (out_echo_busy),
    .out_byte_dropped (out_byte_dropped)
  );

endmodule

// ===== sim/uart_line_echo_tb.sv =====
// uart_line_echo_tb: self-checking bench for the UART line echo block.
// Drives serial frames tick by tick, predicts untyped results, compares field by field.
// Depends on ule_pkg and uart_line_echo.
`timescale 1ns / 1ps

module uart_line_echo_tb;
  import ule_pkg::*;

  localparam int LINE_DEPTH  = 128;
  localparam int M_AW        = $clog2(LINE_DEPTH);
  localparam int DRAIN_GAP   = 8;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_TICKS = 150;

  typedef struct packed {
    logic              tx_level;
    logic              byte_done;
    logic [BYTE_W-1:0] byte_value;
    logic              echo_busy;
    logic              byte_dropped;
  } tick_res_t;

  typedef struct packed {
    logic      level;
    logic      typed;
    tick_res_t want;
  } rx_tick_t;

  typedef enum int {
    ROW_IDLE, ROW_LOW, ROW_FRAME, ROW_GLITCH, ROW_PART, ROW_FILL, ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    int        arg;
    int        arg2;
    bit        typed;
  } stim_row_t;

  localparam tick_res_t IDLE_RES = '{1'b1, 1'b0, 8'h00, 1'b0, 1'b0};

  // FRAME: byte, stop level; PART: byte, bit times sent; FILL: byte count;
  // CFG: register, value; IDLE: ticks high; LOW: ticks low; GLITCH: ticks low.
  localparam int N_ROWS = 30;
  stim_row_t dir_rows [N_ROWS] = '{
    '{ROW_IDLE,   16,            0,    1'b1},
    '{ROW_GLITCH, 3,             0,    1'b1},
    '{ROW_CFG,    REG_BIT_TICKS, 4,    1'b0},
    '{ROW_FRAME,  'h41,          1,    1'b0},
    '{ROW_FRAME,  'h00,          1,    1'b0},
    '{ROW_FRAME,  'hFF,          1,    1'b0},
    '{ROW_FRAME,  'h55,          0,    1'b0},
    '{ROW_IDLE,   60,            0,    1'b0},
    '{ROW_FRAME,  'h0D,          1,    1'b0},
    '{ROW_FRAME,  'h33,          1,    1'b0},
    '{ROW_IDLE,   200,           0,    1'b0},
    '{ROW_CFG,    REG_LINE_END,  0,    1'b0},
    '{ROW_FRAME,  'h00,          1,    1'b0},
    '{ROW_IDLE,   60,            0,    1'b0},
    '{ROW_CFG,    REG_LINE_END,  255,  1'b0},
    '{ROW_CFG,    REG_BIT_TICKS, 12,   1'b0},
    '{ROW_PART,   'hA5,          5,    1'b0},
    '{ROW_CFG,    REG_BIT_TICKS, 4,    1'b0},
    '{ROW_IDLE,   60,            0,    1'b0},
    '{ROW_CFG,    REG_BIT_TICKS, 4095, 1'b0},
    '{ROW_LOW,    20,            0,    1'b0},
    '{ROW_CFG,    REG_BIT_TICKS, 4,    1'b0},
    '{ROW_IDLE,   10,            0,    1'b0},
    '{ROW_CFG,    REG_BIT_TICKS, 2,    1'b0},
    '{ROW_FILL,   128,           0,    1'b0},
    '{ROW_FRAME,  'hFF,          1,    1'b0},
    '{ROW_CFG,    REG_BIT_TICKS, 1,    1'b0},
    '{ROW_IDLE,   1300,          0,    1'b0},
    '{ROW_CFG,    REG_BIT_TICKS, 4,    1'b0},
    '{ROW_IDLE,   60,            0,    1'b0}
  };

  int send_mode [4] = '{0, 47, 0, 8};
  int recv_mode [4] = '{0, 0, 47, 8};

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_rx_level = 1'b1;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_tx_level;
  logic              out_byte_done;
  logic [BYTE_W-1:0] out_byte_value;
  logic              out_echo_busy;
  logic              out_byte_dropped;
  logic              cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = REG_BIT_TICKS;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  uart_line_echo #(.LINE_DEPTH(LINE_DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_level      (in_rx_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tx_level     (out_tx_level),
    .out_byte_done    (out_byte_done),
    .out_byte_value   (out_byte_value),
    .out_echo_busy    (out_echo_busy),
    .out_byte_dropped (out_byte_dropped),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  // Predictor state
  logic [TICK_W-1:0] m_bit_ticks;
  logic [BYTE_W-1:0] m_line_end;
  phase_t            m_rx_phase;
  logic [TICK_W-1:0] m_rx_cnt;
  logic [2:0]        m_rx_bits;
  logic [BYTE_W-1:0] m_rx_shift;
  logic [BYTE_W-1:0] m_store [LINE_DEPTH];
  logic [7:0]        m_fill;
  phase_t            m_tx_phase;
  logic [TICK_W-1:0] m_tx_cnt;
  logic [3:0]        m_tx_bits;
  logic [BYTE_W-1:0] m_tx_shift;
  logic [7:0]        m_send_idx;

  rx_tick_t  tick_q [$];
  tick_res_t tick_results_q [$];
  rx_tick_t  cur_tick;
  tick_res_t pred_res;
  tick_res_t want_res;
  bit        in_taken = 1'b0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        pushed_ticks = 0;
  int        out_count = 0;
  int        err_count = 0;
  int        cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [TICK_W:0] count_step(logic [TICK_W-1:0] cnt,
                                                 logic [TICK_W-1:0] target);
    logic [TICK_W-1:0] c;
    c = cnt + 1'b1;
    if (c >= target) return {1'b1, {TICK_W{1'b0}}};
    return {1'b0, c};
  endfunction

  task automatic reset_model();
    m_bit_ticks = BIT_TICKS_RST;
    m_line_end  = LINE_END_RST;
    m_rx_phase  = PH_IDLE;
    m_rx_cnt    = '0;
    m_rx_bits   = '0;
    m_rx_shift  = '0;
    for (int i = 0; i < LINE_DEPTH; i++) m_store[i] = '0;
    m_fill      = '0;
    m_tx_phase  = PH_IDLE;
    m_tx_cnt    = '0;
    m_tx_bits   = '0;
    m_tx_shift  = '0;
    m_send_idx  = '0;
  endtask

  task automatic load_tx_byte(input logic [7:0] idx);
    m_tx_shift = (int'(idx) < LINE_DEPTH) ? m_store[idx[M_AW-1:0]] : '0;
    m_tx_phase = PH_START;
    m_tx_cnt   = '0;
    m_tx_bits  = '0;
  endtask

  task automatic predict_tick(input logic level, output tick_res_t r);
    logic busy;
    logic hit;
    logic start_echo;
    r          = '0;
    r.tx_level = 1'b1;
    busy       = (m_tx_phase != PH_IDLE);
    start_echo = 1'b0;
    if (m_tx_phase == PH_START) r.tx_level = 1'b0;
    else if (m_tx_phase == PH_DATA) r.tx_level = m_tx_shift[0];
    r.echo_busy = busy;

    case (m_rx_phase)
      PH_IDLE: begin
        if (!level) begin
          m_rx_phase = PH_START;
          m_rx_cnt   = '0;
        end
      end
      PH_START: begin
        {hit, m_rx_cnt} = count_step(m_rx_cnt, m_bit_ticks >> 1);
        if (hit) begin
          if (level) begin
            m_rx_phase = PH_IDLE;
          end else begin
            m_rx_phase = PH_DATA;
            m_rx_bits  = '0;
            m_rx_shift = '0;
          end
        end
      end
      PH_DATA: begin
        {hit, m_rx_cnt} = count_step(m_rx_cnt, m_bit_ticks);
        if (hit) begin
          m_rx_shift = {level, m_rx_shift[BYTE_W-1:1]};
          if (m_rx_bits == 3'd7) m_rx_phase = PH_STOP;
          else m_rx_bits = m_rx_bits + 1'b1;
        end
      end
      default: begin
        {hit, m_rx_cnt} = count_step(m_rx_cnt, m_bit_ticks);
        if (hit) begin
          m_rx_phase   = PH_IDLE;
          m_rx_bits    = '0;
          r.byte_done  = 1'b1;
          r.byte_value = m_rx_shift;
          if (busy) begin
            r.byte_dropped = 1'b1;
          end else if (m_rx_shift == m_line_end) begin
            if (int'(m_fill) < LINE_DEPTH) begin
              m_store[m_fill[M_AW-1:0]] = m_rx_shift;
              m_fill = m_fill + 1'b1;
            end
            start_echo = 1'b1;
          end else if (int'(m_fill) + 1 < LINE_DEPTH) begin
            m_store[m_fill[M_AW-1:0]] = m_rx_shift;
            m_fill = m_fill + 1'b1;
          end else begin
            r.byte_dropped = 1'b1;
          end
        end
      end
    endcase

    if (m_tx_phase != PH_IDLE) begin
      {hit, m_tx_cnt} = count_step(m_tx_cnt, m_bit_ticks);
      if (hit) begin
        case (m_tx_phase)
          PH_START: begin
            m_tx_phase = PH_DATA;
            m_tx_bits  = '0;
          end
          PH_DATA: begin
            m_tx_shift = m_tx_shift >> 1;
            m_tx_bits  = m_tx_bits + 1'b1;
            if (m_tx_bits >= 4'd8) m_tx_phase = PH_STOP;
          end
          default: begin
            m_send_idx = m_send_idx + 1'b1;
            if (m_send_idx < m_fill) begin
              load_tx_byte(m_send_idx);
            end else begin
              m_tx_phase = PH_IDLE;
              m_tx_cnt   = '0;
              m_tx_bits  = '0;
              m_tx_shift = '0;
              m_send_idx = '0;
              m_fill     = '0;
            end
          end
        endcase
      end
    end

    if (start_echo && m_fill != 0) begin
      m_send_idx = '0;
      load_tx_byte(8'd0);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < 40)
      $display("mismatch at result %0d, %s: got %0d, expected %0d", out_count, what, got, want);
    err_count++;
  endtask

  task automatic push_tick(input logic level, input logic typed);
    tick_q.push_back('{level, typed, IDLE_RES});
    pushed_ticks++;
  endtask

  // Bit times 0..nbits-1 of an 8N1 frame: start, eight data bits LSB first, stop.
  task automatic push_frame(input logic [7:0] data, input logic stop, input int nbits);
    logic [9:0] bits;
    bits = {stop, data, 1'b0};
    for (int j = 0; j < nbits; j++)
      repeat (m_bit_ticks) push_tick(bits[j], 1'b0);
  endtask

  task automatic push_glitch(input int low_ticks, input logic typed);
    repeat (low_ticks) push_tick(1'b0, typed);
    repeat ((m_bit_ticks >> 1) + 2) push_tick(1'b1, typed);
  endtask

  task automatic wait_drain();
    while (tick_q.size() != 0 || in_valid || tick_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    wait_drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BIT_TICKS) m_bit_ticks = val;
    else m_line_end = val[BYTE_W-1:0];
  endtask

  // Sender and receiver pacing
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_tick = tick_q.pop_front();
        in_valid    <= 1'b1;
        in_rx_level <= cur_tick.level;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Transaction monitor and checker
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        predict_tick(cur_tick.level, pred_res);
        tick_results_q.push_back(cur_tick.typed ? cur_tick.want : pred_res);
      end
      if (out_valid && out_ready) begin
        if (tick_results_q.size() == 0) begin
          report_mismatch("result with nothing expected", 1, 0);
        end else begin
          want_res = tick_results_q.pop_front();
          if (out_tx_level !== want_res.tx_level)
            report_mismatch("tx_level", out_tx_level, want_res.tx_level);
          if (out_byte_done !== want_res.byte_done)
            report_mismatch("byte_done", out_byte_done, want_res.byte_done);
          if (out_byte_value !== want_res.byte_value)
            report_mismatch("byte_value", out_byte_value, want_res.byte_value);
          if (out_echo_busy !== want_res.echo_busy)
            report_mismatch("echo_busy", out_echo_busy, want_res.echo_busy);
          if (out_byte_dropped !== want_res.byte_dropped)
            report_mismatch("byte_dropped", out_byte_dropped, want_res.byte_dropped);
        end
        out_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               tick_results_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    stim_row_t   row;
    logic [7:0]  b;
    int          pick;
    int          mark;
    bit          paused;

    reset_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      case (row.kind)
        ROW_IDLE:   repeat (row.arg) push_tick(1'b1, row.typed);
        ROW_LOW:    repeat (row.arg) push_tick(1'b0, row.typed);
        ROW_GLITCH: push_glitch(row.arg, row.typed);
        ROW_FRAME: begin
          push_frame(row.arg[7:0], row.arg2[0], 10);
          repeat (2) push_tick(1'b1, 1'b0);
        end
        ROW_PART:   push_frame(row.arg[7:0], 1'b1, row.arg2);
        ROW_FILL: begin
          repeat (row.arg) begin
            do b = 8'($urandom_range(255)); while (b == m_line_end);
            push_frame(b, 1'b1, 10);
          end
        end
        default:    write_reg(cfg_reg_t'(row.arg), row.arg2[CFG_W-1:0]);
      endcase
    end

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_BIT_TICKS, CFG_W'($urandom_range(7, 4)));
      write_reg(REG_LINE_END, CFG_W'($urandom_range(255)));
      send_idle_pct  = send_mode[ph % 4];
      recv_stall_pct = recv_mode[ph % 4];
      mark   = pushed_ticks;
      paused = 1'b0;
      while (pushed_ticks - mark < PHASE_TICKS) begin
        if (!paused && pushed_ticks - mark >= PHASE_TICKS / 2) begin
          wait_drain();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        b = ($urandom_range(99) < 30) ? m_line_end : 8'($urandom_range(255));
        if (pick < 80) begin
          push_frame(b, 1'b1, 10);
        end else if (pick < 87) begin
          push_glitch($urandom_range((m_bit_ticks >> 1) - 1, 1), 1'b0);
        end else if (pick < 94) begin
          push_frame(b, 1'b0, 10);
        end else begin
          repeat (8) push_tick($urandom_range(1), 1'b0);
        end
        repeat ($urandom_range(3)) push_tick(1'b1, 1'b0);
      end
    end

    wait_drain();
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
